// File: rtl/bist_pkg.sv
// ----------------------------------------------------------------------------
// bist_pkg
// shared constants, codes and controller/datapath interface types for the
// bounded integer set table
// ----------------------------------------------------------------------------
package bist_pkg;

  // default sizing
  localparam int unsigned DefaultCapacity   = 64;
  localparam int unsigned DefaultValueWidth = 32;

  // fixed field widths
  localparam int unsigned ModeWidth   = 2;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CountWidth  = 7;
  localparam int unsigned ItemWidth   = 32;

  // operation codes (code 3 acts as a query)
  localparam logic [ModeWidth-1:0] MODE_ADD    = 2'd0;
  localparam logic [ModeWidth-1:0] MODE_REMOVE = 2'd1;
  localparam logic [ModeWidth-1:0] MODE_QUERY  = 2'd2;

  // result status codes
  localparam logic [StatusWidth-1:0] ST_DONE = 2'd0;
  localparam logic [StatusWidth-1:0] ST_MISS = 2'd1;
  localparam logic [StatusWidth-1:0] ST_FULL = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch item, restart scan
    logic issue;     // read slot at scan index, advance it
    logic shift_wr;  // write last read data one slot lower
    logic finish;    // commit and present the result
    logic found;     // value was present (valid with finish)
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pend;       // read data belongs to an issued slot
    logic hit;        // pending read data equals the item value
    logic more;       // scan index still below the held count
    logic is_remove;  // latched operation is a remove
  } dp_stat_t;

endpackage

// File: rtl/bist_ram.sv
// ----------------------------------------------------------------------------
// bist_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bist_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bist_ctrl.sv
// ----------------------------------------------------------------------------
// bist_ctrl
// sequencer for scan, compaction shift and result commit
// ----------------------------------------------------------------------------
module bist_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  bist_pkg::dp_stat_t stat_i,
  output bist_pkg::dp_cmd_t  cmd_o
);
  import bist_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (stat_i.hit) begin
          if (stat_i.is_remove) begin
            state_d = S_SHIFT;
          end else begin
            cmd_o.finish = 1'b1;
            cmd_o.found  = 1'b1;
            state_d      = S_IDLE;
          end
        end else if (stat_i.more) begin
          cmd_o.issue = 1'b1;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SHIFT: begin
        cmd_o.shift_wr = stat_i.pend;
        cmd_o.issue    = stat_i.more;
        if (!stat_i.pend && !stat_i.more) begin
          cmd_o.finish = 1'b1;
          cmd_o.found  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// File: rtl/bist_dp.sv
// ----------------------------------------------------------------------------
// bist_dp
// item registers, slot store, scan pointer, held count and result registers
// ----------------------------------------------------------------------------
module bist_dp #(
  parameter int unsigned Capacity   = bist_pkg::DefaultCapacity,
  parameter int unsigned ValueWidth = bist_pkg::DefaultValueWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [bist_pkg::ModeWidth-1:0]      mode_i,
  input  logic signed [bist_pkg::ItemWidth-1:0] item_value_i,
  input  bist_pkg::dp_cmd_t                   cmd_i,
  output bist_pkg::dp_stat_t                  stat_o,
  output logic                                done_o,
  output logic [bist_pkg::StatusWidth-1:0]    status_o,
  output logic                                found_o,
  output logic [bist_pkg::CountWidth-1:0]     member_count_o
);
  import bist_pkg::*;

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);

  logic [ModeWidth-1:0]  mode_q;
  logic [ValueWidth-1:0] value_q;
  logic [ValueWidth-1:0] value_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         scan_q;
  logic [AW-1:0]         rd_addr_q;
  logic                  pend_q;
  logic                  done_q;
  logic [StatusWidth-1:0] status_q, status_d;
  logic                  found_q;

  logic                  full;
  logic                  add_wr;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [ValueWidth-1:0] wdata;
  logic [ValueWidth-1:0] rdata;
  logic [ValueWidth+ItemWidth-1:0] value_ext;
  logic [CW+CountWidth-1:0]        count_ext;

  // sign extend, then keep the stored width
  assign value_ext = {{ValueWidth{item_value_i[ItemWidth-1]}}, item_value_i};
  assign value_d   = value_ext[ValueWidth-1:0];

  assign full   = (count_q == CW'(Capacity));
  assign add_wr = cmd_i.finish && (mode_q == MODE_ADD) && !cmd_i.found && !full;

  assign we    = cmd_i.shift_wr || add_wr;
  assign waddr = cmd_i.shift_wr ? (rd_addr_q - AW'(1)) : count_q[AW-1:0];
  assign wdata = cmd_i.shift_wr ? rdata : value_q;

  bist_ram #(
    .Width (ValueWidth),
    .Depth (Capacity)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.issue),
    .raddr_i (scan_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign stat_o.pend      = pend_q;
  assign stat_o.hit       = pend_q && (rdata == value_q);
  assign stat_o.more      = (scan_q < count_q);
  assign stat_o.is_remove = (mode_q == MODE_REMOVE);

  // result status and new count
  always_comb begin
    count_d  = count_q;
    status_d = cmd_i.found ? ST_DONE : ST_MISS;
    unique case (mode_q)
      MODE_ADD: begin
        priority if (full) begin
          status_d = ST_FULL;
        end else if (cmd_i.found) begin
          status_d = ST_MISS;
        end else begin
          status_d = ST_DONE;
          count_d  = count_q + CW'(1);
        end
      end
      MODE_REMOVE: begin
        if (cmd_i.found) begin
          count_d = count_q - CW'(1);
        end
      end
      MODE_QUERY: begin
        status_d = cmd_i.found ? ST_DONE : ST_MISS;
      end
      default: begin
        status_d = cmd_i.found ? ST_DONE : ST_MISS;
      end
    endcase
  end

  // item registers, read address and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      value_q <= value_d;
    end
    if (cmd_i.issue) begin
      rd_addr_q <= scan_q[AW-1:0];
    end
    if (cmd_i.finish) begin
      status_q <= status_d;
      found_q  <= cmd_i.found;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      scan_q  <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      pend_q <= cmd_i.issue;
      if (cmd_i.load) begin
        scan_q <= '0;
      end else if (cmd_i.issue) begin
        scan_q <= scan_q + CW'(1);
      end
      if (cmd_i.finish) begin
        count_q <= count_d;
      end
    end
  end

  assign count_ext      = {{CountWidth{1'b0}}, count_q};
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign member_count_o = count_ext[CountWidth-1:0];

endmodule

// File: rtl/bounded_integer_set_table_top.sv
// ----------------------------------------------------------------------------
// bounded_integer_set_table_top
// bounded set of distinct signed values kept packed in the low ram slots
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ---------------------------------
//  command   in         start & !busy          mode_i, item_value_i
//  result    out        done_o, one cycle      status_o, found_o, member_count_o
//
//  scan: the slot ram has one read port, so the held values are scanned one
//  per cycle. a miss scans every held value, a hit ends the scan at the
//  matching slot, and a remove then moves each value above that slot one
//  slot down for the compaction.
//  reset: asynchronous, active low; clears the held count and the sequencer,
//  slot contents stay undefined and are never read before being written.
//  stalls: results cannot be held off; busy stays high from the command
//  transfer until the result strobe, when a new command may be taken.
//
module bounded_integer_set_table_top #(
  parameter int unsigned CAPACITY    = bist_pkg::DefaultCapacity,
  parameter int unsigned VALUE_WIDTH = bist_pkg::DefaultValueWidth
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // command transfer
  input  logic                                  start,
  output logic                                  busy,
  input  logic [bist_pkg::ModeWidth-1:0]        mode_i,
  input  logic signed [bist_pkg::ItemWidth-1:0] item_value_i,
  // result transfer
  output logic                                  done_o,
  output logic [bist_pkg::StatusWidth-1:0]      status_o,
  output logic                                  found_o,
  output logic [bist_pkg::CountWidth-1:0]       member_count_o
);
  import bist_pkg::*;

  dp_cmd_t  cmd;   // sequencer commands to the datapath
  dp_stat_t stat;  // compare and pointer status back

  // scan, shift and commit sequencing
  bist_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // slot ram, compare, held count and result registers
  bist_dp #(
    .Capacity   (CAPACITY),
    .ValueWidth (VALUE_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_i),
    .item_value_i   (item_value_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .done_o         (done_o),
    .status_o       (status_o),
    .found_o        (found_o),
    .member_count_o (member_count_o)
  );

endmodule
